// File: hdl/msxt_pkg.sv
// Shared types and constants for the multi-set max-XOR trie block.
// Holds the request and response structs, status and command codes, and the
// sequencer state type. Depends on nothing.
package msxt_pkg;

   localparam int SET_IDX_W = 10;
   localparam int KEY_W     = 21;
   localparam int STATUS_W  = 2;
   localparam int MOD_CNT_W = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                 cmd;
      logic [SET_IDX_W-1:0] set_index;
      logic [KEY_W-1:0]     key_value;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]    best_xor;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_ROOT,
      ST_START,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic hit;
      logic alloc;
      logic dead;
   } step_flags_type;

endpackage

// File: hdl/msxt_ram.sv
// Simple dual-port memory: one write port and one read port with registered read data.
// Used for the per-set root table and for the shared trie node store. No dependencies.
module msxt_ram #(
   parameter  int DEPTH = 16,
   parameter  int WIDTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/msxt_step.sv
// One trie level: chooses the branch to follow and, for an insert, the link to add.
// Shared by every level of every request. Depends on msxt_pkg.
module msxt_step #(
   parameter int NODE_W = 14
) (
   input  logic                    is_query,
   input  logic                    key_bit,
   input  logic [NODE_W-1:0]       link0,
   input  logic [NODE_W-1:0]       link1,
   input  logic [NODE_W-1:0]       new_node,
   output logic [NODE_W-1:0]       next_node,
   output logic [NODE_W-1:0]       wr_link0,
   output logic [NODE_W-1:0]       wr_link1,
   output msxt_pkg::step_flags_type flags
);
   import msxt_pkg::*;

   logic              want;
   logic [NODE_W-1:0] pref;
   logic [NODE_W-1:0] other;

   // A query prefers the branch opposite to the key bit; an insert follows the key bit.
   always_comb begin
      want      = is_query ? ~key_bit : key_bit;
      pref      = want ? link1 : link0;
      other     = want ? link0 : link1;
      flags     = '0;
      wr_link0  = link0;
      wr_link1  = link1;
      next_node = pref;
      if (is_query) begin
         if (pref != '0) begin
            flags.hit = 1'b1;
         end else begin
            next_node = other;
         end
         flags.dead = (next_node == '0);
      end else begin
         if (pref == '0) begin
            flags.alloc = 1'b1;
            next_node   = new_node;
            if (key_bit) begin
               wr_link1 = new_node;
            end else begin
               wr_link0 = new_node;
            end
         end
      end
   end

endmodule

// File: hdl/multi_set_max_xor_trie.sv
// Top level of the multi-set max-XOR trie: sequencer, root table, node store and level unit.
// Depends on msxt_pkg, msxt_ram and msxt_step.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+---------------------------------
//   request | req_valid, req_ready, req_data | in        | cmd, set_index, key_value
//   result  | rsp_valid, rsp_ready, rsp_data | out       | best_xor, status
//
// A request passes through acceptance, a root table read, a start step, one node store
// read per trie level and the result load. When NUM_SETS is below 1024 and not a power
// of two, the set index is first reduced in ST_MOD, the quotient first and then the
// remainder. The node store's single read port sets the level rate. After reset the
// root table is cleared, one entry a cycle, before the first request is taken. A
// finished result waits in its register while the next request is accepted; that
// request stalls at its end until the result is taken.
module multi_set_max_xor_trie #(
   parameter int VALUE_BITS = 21,
   parameter int NUM_SETS   = 1024,
   parameter int POOL_NODES = 16384
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msxt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msxt_pkg::rsp_type rsp_data
);
   import msxt_pkg::*;

   localparam int NODE_W     = $clog2(POOL_NODES);
   localparam int SET_AW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int LVL_W      = $clog2(VALUE_BITS);
   localparam int FULL_LIMIT = POOL_NODES - VALUE_BITS - 2;
   localparam int MOD_W      = 2 * SET_IDX_W;
   localparam int MOD_PROD_W = MOD_W + SET_IDX_W;
   localparam bit MOD_NEEDED = (NUM_SETS < (1 << SET_IDX_W)) &&
                               ((NUM_SETS & (NUM_SETS - 1)) != 0);
   localparam logic [MOD_W-1:0] MOD_RECIP = MOD_W'((1 << MOD_W) / NUM_SETS + 1);

   state_type             state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [SET_IDX_W-1:0]  set_ff, set_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [NODE_W-1:0]     cur_ff, cur_in;
   logic                  fresh_ff, fresh_in;
   logic [NODE_W-1:0]     used_ff, used_in;
   logic [SET_AW-1:0]     clr_ff, clr_in;
   logic [MOD_W-1:0]      div_ff, div_in;
   logic [MOD_CNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  is_query;
   logic                  pool_full;
   logic [NODE_W-1:0]     new_node;
   logic [SET_AW-1:0]     set_addr;
   logic                  rsp_load;
   logic [MOD_PROD_W-1:0] mod_prod;
   logic [MOD_W-1:0]      mod_back;

   logic                  root_we;
   logic [SET_AW-1:0]     root_waddr;
   logic [NODE_W-1:0]     root_wdata;
   logic [NODE_W-1:0]     root_rdata;

   logic                  node_we;
   logic [NODE_W-1:0]     node_raddr;
   logic [2*NODE_W-1:0]   node_rdata;
   logic [NODE_W-1:0]     link0, link1;
   logic [NODE_W-1:0]     step_next;
   logic [NODE_W-1:0]     wr_link0, wr_link1;
   step_flags_type        step_flags;

   assign is_query  = (cmd_ff == CMD_QUERY);
   assign pool_full = (used_ff > NODE_W'(FULL_LIMIT));
   assign new_node  = used_ff + NODE_W'(1);
   assign set_addr  = (NUM_SETS > 1) ? SET_AW'(set_ff) : '0;
   assign mod_prod  = MOD_PROD_W'(set_ff) * MOD_PROD_W'(MOD_RECIP);
   assign mod_back  = div_ff * MOD_W'(NUM_SETS);

   // A freshly taken node has no links yet, so its stale memory word is ignored.
   assign link0 = fresh_ff ? '0 : node_rdata[NODE_W-1:0];
   assign link1 = fresh_ff ? '0 : node_rdata[2*NODE_W-1:NODE_W];

   msxt_ram #(
      .DEPTH (NUM_SETS),
      .WIDTH (NODE_W)
   ) u_root_ram (
      .clock   (clock),
      .we      (root_we),
      .waddr   (root_waddr),
      .wdata   (root_wdata),
      .raddr   (set_addr),
      .rd_data (root_rdata)
   );

   msxt_ram #(
      .DEPTH (POOL_NODES),
      .WIDTH (2 * NODE_W)
   ) u_node_ram (
      .clock   (clock),
      .we      (node_we),
      .waddr   (cur_ff),
      .wdata   ({wr_link1, wr_link0}),
      .raddr   (node_raddr),
      .rd_data (node_rdata)
   );

   msxt_step #(
      .NODE_W (NODE_W)
   ) u_step (
      .is_query  (is_query),
      .key_bit   (key_ff[lvl_ff]),
      .link0     (link0),
      .link1     (link1),
      .new_node  (new_node),
      .next_node (step_next),
      .wr_link0  (wr_link0),
      .wr_link1  (wr_link1),
      .flags     (step_flags)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_AW'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = MOD_NEEDED ? ST_MOD : ST_ROOT;
            end
         end
         ST_MOD: begin
            if (mod_cnt_ff == '0) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            state_in = ST_START;
         end
         ST_START: begin
            if (is_query) begin
               state_in = (root_rdata == '0) ? ST_DONE : ST_WALK;
            end else begin
               state_in = pool_full ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (lvl_ff == '0 || step_flags.dead) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and memory controls
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      root_we    = 1'b0;
      root_waddr = set_addr;
      root_wdata = new_node;
      node_we    = 1'b0;
      node_raddr = step_next;
      case (state_ff)
         ST_CLEAR: begin
            root_we    = 1'b1;
            root_waddr = clr_ff;
            root_wdata = '0;
         end
         ST_START: begin
            node_raddr = root_rdata;
            root_we    = !is_query && !pool_full && (root_rdata == '0);
         end
         ST_WALK: begin
            node_we = !is_query && step_flags.alloc;
         end
         default: begin
            root_we = 1'b0;
         end
      endcase
   end

   // Datapath
   always_comb begin
      cmd_in       = cmd_ff;
      set_in       = set_ff;
      key_in       = key_ff;
      best_in      = best_ff;
      status_in    = status_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      fresh_in     = fresh_ff;
      used_in      = used_ff;
      clr_in       = clr_ff;
      div_in       = div_ff;
      mod_cnt_in   = mod_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_AW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               set_in     = req_data.set_index;
               key_in     = VALUE_BITS'(req_data.key_value);
               best_in    = '0;
               status_in  = STATUS_DONE;
               lvl_in     = LVL_W'(VALUE_BITS - 1);
               mod_cnt_in = MOD_CNT_W'(1);
            end
         end
         ST_MOD: begin
            // Reciprocal reduction: the quotient first, then the remainder from it.
            if (mod_cnt_ff != '0) begin
               div_in = MOD_W'(mod_prod[MOD_PROD_W-1:MOD_W]);
            end else begin
               set_in = set_ff - mod_back[SET_IDX_W-1:0];
            end
            mod_cnt_in = mod_cnt_ff - MOD_CNT_W'(1);
         end
         ST_START: begin
            if (is_query) begin
               if (root_rdata == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  cur_in   = root_rdata;
                  fresh_in = 1'b0;
               end
            end else if (pool_full) begin
               status_in = STATUS_FULL;
            end else if (root_rdata == '0) begin
               cur_in   = new_node;
               fresh_in = 1'b1;
               used_in  = new_node;
            end else begin
               cur_in   = root_rdata;
               fresh_in = 1'b0;
            end
         end
         ST_WALK: begin
            cur_in   = step_next;
            fresh_in = step_flags.alloc;
            lvl_in   = lvl_ff - LVL_W'(1);
            if (!is_query && step_flags.alloc) begin
               used_in = new_node;
            end
            if (step_flags.hit) begin
               best_in[lvl_ff] = 1'b1;
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_in.best_xor = KEY_W'(best_ff);
         rsp_in.status   = status_ff;
         rsp_valid_in    = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         used_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      set_ff     <= set_in;
      key_ff     <= key_in;
      best_ff    <= best_in;
      status_ff  <= status_in;
      lvl_ff     <= lvl_in;
      cur_ff     <= cur_in;
      fresh_ff   <= fresh_in;
      div_ff     <= div_in;
      mod_cnt_ff <= mod_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The node count only grows between resets.
   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> used_ff >= $past(used_ff))
      else $error("node count went backwards");

   // Every link written during a walk takes exactly one fresh node.
   a_alloc_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && node_we) |=> used_ff == $past(used_ff) + NODE_W'(1))
      else $error("node allocation and count disagree");

   // A query on an empty set reports no XOR value.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_EMPTY) |-> rsp_ff.best_xor == '0)
      else $error("empty set result carries a value");

endmodule
